// File: rtl/mhdf_pkg.sv
package mhdf_pkg;

  // Command codes carried in the input item
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] msg_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic        is_new;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FINISH,
    S_SCAN,
    S_RESULT
  } state_t;

  // Control from the sequencer to the hash table
  typedef struct packed {
    logic clear;
    logic store;
    logic rd_en;
  } tbl_ctrl_t;

  // One-at-a-time absorb step for one byte
  function automatic logic [31:0] absorb(input logic [31:0] h_in, input logic [7:0] b);
    logic [31:0] h;
    h = h_in + {24'd0, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // Final avalanche mix
  function automatic logic [31:0] finish(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

endpackage

// File: rtl/message_hash_dedup_filter_core.sv
// Message hash duplicate filter. Bytes stream in and are folded into a
// one-at-a-time hash; the byte marked last triggers the final mix and a search
// of the table of earlier message hashes. A result (hash and new/seen flag) is
// given for each completed message; a new hash is stored at the next slot,
// overwriting the oldest once the table has wrapped. A zero hash counts as seen
// while any slot is still empty. A clear command empties the table at once and
// gives no result; a message in progress continues across it. A final byte is
// handled in steps: it is accepted, the final mix is applied, the filled slots
// (up to TABLE_DEPTH) are searched, one entry per cycle through a single read
// port, and the result is handed over. That last step waits for as long as an
// earlier result is still held by a stall. No clearing pass is needed after
// reset.
module message_hash_dedup_filter_core import mhdf_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t      state, state_next;
  logic [31:0] hash;
  logic        found;
  logic [AW:0] issue;
  logic        rd_pend;

  tbl_ctrl_t   ctrl;
  logic [31:0] rd_data;
  logic [AW:0] fill;
  logic        has_empty;

  logic        item_xfer;
  logic        out_free;
  logic        hit;

  assign item_xfer = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign hit       = found || (hash == 32'd0 && has_empty);

  mhdf_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rd_addr  (issue[AW-1:0]),
    .rd_data  (rd_data),
    .wr_data  (hash),
    .fill     (fill),
    .has_empty(has_empty)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_xfer && item.cmd == CMD_BYTE && item.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_SCAN;
      S_SCAN: begin
        if (issue == fill && !rd_pend) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    item_stall = (state != S_IDLE);
    ctrl.clear = item_xfer && item.cmd == CMD_CLEAR;
    ctrl.rd_en = (state == S_SCAN) && (issue != fill);
    ctrl.store = (state == S_RESULT) && out_free && !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running hash, search counters and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hash    <= '0;
      found   <= 1'b0;
      issue   <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_xfer && item.cmd == CMD_BYTE) begin
            hash <= absorb(hash, item.msg_byte);
          end
          found   <= 1'b0;
          issue   <= '0;
          rd_pend <= 1'b0;
        end
        S_FINISH: hash <= finish(hash);
        S_SCAN: begin
          rd_pend <= ctrl.rd_en;
          if (ctrl.rd_en) begin
            issue <= issue + 1'b1;
          end
          if (rd_pend && rd_data == hash) begin
            found <= 1'b1;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            hash <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      result.hash_value <= hash;
      result.is_new     <= !hit;
    end
  end

endmodule

// File: rtl/mhdf_table.sv
module mhdf_table import mhdf_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tbl_ctrl_t                        ctrl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  output logic [31:0]                      rd_data,
  input  logic [31:0]                      wr_data,
  output logic [$clog2(TABLE_DEPTH):0]     fill,
  output logic                             has_empty
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  logic [31:0]   mem [TABLE_DEPTH];
  logic [AW-1:0] slot;
  logic          wrapped;

  // Synchronous read port
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port: new hashes go to the current slot
  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      mem[slot] <= wr_data;
    end
  end

  // Slot pointer and fill tracking; entries past the fill point count as empty
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot    <= '0;
      wrapped <= 1'b0;
    end else if (ctrl.store) begin
      if (slot == AW'(TABLE_DEPTH - 1)) begin
        slot    <= '0;
        wrapped <= 1'b1;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  assign fill      = wrapped ? CW'(TABLE_DEPTH) : {1'b0, slot};
  assign has_empty = !wrapped;

endmodule

// File: sim/testbench.sv
module testbench;
  import mhdf_pkg::*;

  localparam int TABLE_DEPTH     = 32;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int POOL_SIZE       = 16;
  localparam int MAX_LEN         = 40;

  // Expected-result tracker: mirrors hash state, seen table and write slot
  class dedup_scoreboard;
    logic [31:0] msg_hash;
    logic [31:0] seen_hashes [TABLE_DEPTH];
    int unsigned next_slot;
    result_t     pending_results [$];
    int          mismatches;

    function void reset_state();
      msg_hash = '0;
      foreach (seen_hashes[i]) seen_hashes[i] = '0;
      next_slot = 0;
      pending_results.delete();
      mismatches = 0;
    endfunction

    function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
      logic [31:0] x;
      x = h + {24'd0, b};
      x = x + (x << 10);
      x = x ^ (x >> 6);
      return x;
    endfunction

    function logic [31:0] final_mix(logic [31:0] h);
      logic [31:0] x;
      x = h + (h << 3);
      x = x ^ (x >> 11);
      x = x + (x << 15);
      return x;
    endfunction

    // Called for every accepted input transfer
    function void note_transfer(item_t it);
      logic [31:0] h;
      bit          found;
      result_t     r;
      if (it.cmd == CMD_CLEAR) begin
        // table and slot cleared, message in progress kept
        foreach (seen_hashes[i]) seen_hashes[i] = '0;
        next_slot = 0;
        return;
      end
      msg_hash = fold_byte(msg_hash, it.msg_byte);
      if (!it.last) return;
      h = final_mix(msg_hash);
      msg_hash = '0;
      found = 0;
      foreach (seen_hashes[i]) if (seen_hashes[i] == h) found = 1;
      if (!found) begin
        seen_hashes[next_slot] = h;
        next_slot = (next_slot + 1) % TABLE_DEPTH;
      end
      r.hash_value = h;
      r.is_new     = !found;
      pending_results.push_back(r);
    endfunction

    // Called for every accepted result transfer
    function void check_result(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: hash_value %h is_new %b", got.hash_value, got.is_new);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.hash_value !== exp_r.hash_value) begin
        $error("hash_value: expected %h, actual %h", exp_r.hash_value, got.hash_value);
        mismatches++;
      end
      if (got.is_new !== exp_r.is_new) begin
        $error("is_new: expected %b, actual %b", exp_r.is_new, got.is_new);
        mismatches++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  dedup_scoreboard sb;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int cycle_count = 0;

  // message buffer and pool of earlier messages for replays
  logic [7:0] msg_buf [MAX_LEN];
  logic [7:0] pool_bytes [POOL_SIZE][MAX_LEN];
  int         pool_len [POOL_SIZE];
  int         pool_count = 0;
  int         pool_next  = 0;

  message_hash_dedup_filter_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check accepted transfers, stall at random
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_transfer(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    send_item(item_t'{cmd: CMD_BYTE, msg_byte: b, last: l});
  endtask

  task automatic send_clear(input logic [7:0] b, input logic l);
    send_item(item_t'{cmd: CMD_CLEAR, msg_byte: b, last: l});
  endtask

  // Message from msg_buf, with an occasional clear before any of its bytes
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(49) == 0) send_clear(8'($urandom_range(255)), 1'($urandom_range(1)));
      send_byte(msg_buf[i], (i == len - 1));
    end
  endtask

  task automatic directed_part();
    send_byte(8'h00, 1'b1);               // zero hash, reported as seen
    send_byte(8'hFF, 1'b1);               // new
    send_byte(8'hFF, 1'b1);               // duplicate
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h00, 1'b0);               // same message again
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b1);
    send_clear(8'hFF, 1'b1);              // ignored fields set
    send_byte(8'hFF, 1'b1);               // new again after clear
    send_byte(8'h12, 1'b0);               // message continues across clear
    send_clear(8'hAA, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h12, 1'b0);               // same hash, now seen
    send_byte(8'h34, 1'b1);
    send_byte(8'h00, 1'b0);               // all-zero message hashes to zero
    send_byte(8'h00, 1'b1);
  endtask

  task automatic random_phase(input int target);
    int start;
    int r;
    int len;
    int pick;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_clear(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 6) begin
        // zero hash: seen unless the table is full of nonzero hashes
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) msg_buf[i] = 8'h00;
        send_message(len);
      end else if (r < 36 && pool_count > 0) begin
        // replay an earlier message
        pick = $urandom_range(pool_count - 1);
        len  = pool_len[pick];
        for (int i = 0; i < len; i++) msg_buf[i] = pool_bytes[pick][i];
        send_message(len);
      end else begin
        // fresh message, mostly short
        len = ($urandom_range(9) == 0) ? $urandom_range(7, MAX_LEN) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          msg_buf[i] = 8'($urandom_range(255));
          pool_bytes[pool_next][i] = msg_buf[i];
        end
        pool_len[pool_next] = len;
        pool_next = (pool_next + 1) % POOL_SIZE;
        if (pool_count < POOL_SIZE) pool_count++;
        send_message(len);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no idling
    idle_pct  = 0;
    stall_pct = 0;
    directed_part();
    random_phase(ITEMS_PER_PHASE);
    // sender idle
    idle_pct  = 75;
    stall_pct = 0;
    random_phase(ITEMS_PER_PHASE);
    // receiver stalling
    idle_pct  = 0;
    stall_pct = 75;
    random_phase(ITEMS_PER_PHASE);
    // both
    idle_pct  = 14;
    stall_pct = 14;
    random_phase(ITEMS_PER_PHASE);
    item_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mhdf_pkg.sv
rtl/mhdf_table.sv
rtl/message_hash_dedup_filter_core.sv
sim/testbench.sv
